[src/wncp_pkg.sv]
// Shared types and constants for the weighted nearest colour phase classifier.
// No dependencies.
package wncp_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PROD,
        ST_DOT,
        ST_DS1,
        ST_DV1,
        ST_MIX,
        ST_DS2,
        ST_DV2,
        ST_OUT
    } st_t;

    typedef logic [0:0] cfg_idx_t;

    localparam cfg_idx_t CFG_CLUSTER_COUNT = 1'b0;
    localparam cfg_idx_t CFG_DIST_MIX      = 1'b1;

    // divider geometry: 68-bit dividend, 34-bit divisor, 64-bit quotient kept
    localparam int DIV_DW = 68;
    localparam int DIV_VW = 34;
    localparam int DIV_QW = 64;

    localparam logic [33:0] UNUSED_PENALTY = 34'd268435456;

    typedef struct packed {
        logic        start;
        logic [67:0] dividend;
        logic [33:0] divisor;
    } div_req_t;

endpackage

[src/wncp_mul.sv]
// Shared signed 18x18 multiplier used by the load, scoring, dot product and mixing steps.
// Depends on nothing; result is registered by the caller.
module wncp_mul (
    input  logic signed [17:0] a,
    input  logic signed [17:0] b,
    output logic signed [35:0] p
);
    assign p = a * b;
endmodule

[src/wncp_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on wncp_pkg.
module wncp_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  wncp_pkg::div_req_t        req,
    output logic                      done,
    output logic [wncp_pkg::DIV_QW-1:0] quotient
);
    import wncp_pkg::*;

    logic [DIV_DW-1:0] dvd_reg;
    logic [DIV_VW-1:0] dvs_reg;
    logic [DIV_VW-1:0] rem_reg;
    logic [DIV_QW-1:0] quo_reg;
    logic [6:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_VW:0]   trial;
    logic              ge;

    assign trial = {rem_reg, dvd_reg[DIV_DW-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 7'd1);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'(DIV_DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? DIV_VW'(trial - {1'b0, dvs_reg}) : trial[DIV_VW-1:0];
            quo_reg <= {quo_reg[DIV_QW-2:0], ge};
            dvd_reg <= {dvd_reg[DIV_DW-2:0], 1'b0};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

[src/weighted_nearest_color_phase.sv]
// Top level of the weighted nearest colour phase classifier.
// Depends on wncp_pkg, wncp_mul and wncp_div.
//
// One word at a time. A load word is accepted and then makes four passes
// through the shared multiplier. A pixel inside the mask is scored cluster
// by cluster. Each cluster runs:
//   - 3*NCOMPONENTS multiplier steps;
//   - 3 steps for the squared dot product;
//   - a projection divide of 68 steps, plus a start step and a done step;
//   - 4 mixing steps;
//   - a weighting divide of the same length.
// The dot product and projection steps are skipped when dist_mix is zero. A
// masked-out pixel goes from the accepting cycle straight to the result word.
// The step counts are set by the single 18x18 multiplier and the bit-serial
// divider. in_ready is high only when the block is idle; the result word is
// held until out_ready.
module weighted_nearest_color_phase #(
    parameter int NCLUSTERS   = 8,
    parameter int NCOMPONENTS = 3
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   action,
    input  logic [2:0]             entry_index,
    input  logic signed [8:0]      level_a,
    input  logic signed [8:0]      level_b,
    input  logic signed [8:0]      level_c,
    input  logic [15:0]            entry_weight,
    input  logic [7:0]             entry_phase,
    input  logic [15:0]            sample_a,
    input  logic [15:0]            sample_b,
    input  logic [15:0]            sample_c,
    input  logic                   in_mask,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             phase_out,
    output logic [2:0]             winner,
    output logic                   classified,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  wncp_pkg::cfg_idx_t     cfg_index,
    input  logic [8:0]             cfg_data
);
    import wncp_pkg::*;

    localparam int IW = (NCLUSTERS > 1) ? $clog2(NCLUSTERS) : 1;
    localparam logic [1:0] KLAST = 2'(NCOMPONENTS - 1);

    // cluster table, one row per entry
    logic [8:0]  lvl_tab [NCLUSTERS][3];
    logic [33:0] norm_tab [NCLUSTERS];
    logic [31:0] wsq_tab [NCLUSTERS];
    logic [7:0]  ph_tab [NCLUSTERS];

    logic [3:0]  cc_reg;
    logic [8:0]  dm_reg;

    st_t state_reg, state_next;

    logic [1:0]    op_reg, k_reg;
    logic [IW-1:0] c_reg, nlast_reg;
    logic [15:0]   s_reg [3];
    logic [8:0]    m_reg;
    logic [8:0]    ld_lvl_reg [3];
    logic [2:0]    ld_idx_reg;
    logic [15:0]   ld_w_reg;
    logic [7:0]    ld_ph_reg;
    logic [17:0]   nacc_reg;

    logic [33:0]        r_reg, sq_reg, line_reg;
    logic signed [34:0] dot_reg;
    logic [67:0]        dsq_reg;
    logic [42:0]        mix_reg;
    logic [63:0]        best_q_reg;

    logic [7:0] ph_out_reg;
    logic [2:0] win_out_reg;
    logic       cls_out_reg;

    logic signed [17:0] mul_a, mul_b;
    logic signed [35:0] prod;
    div_req_t           dreq;
    logic               div_done;
    logic [63:0]        div_q;

    logic [8:0]         cur_lvl;
    logic signed [17:0] cur_d, cur_s, cur_diff;
    logic [33:0]        dot_abs;
    logic [8:0]         mm;
    logic [IW-1:0]      ld_addr;
    logic               ld_in_range;
    int unsigned        n_sat;

    wncp_mul u_mul (.a(mul_a), .b(mul_b), .p(prod));

    wncp_div u_div (
        .clk(clk), .rst_n(rst_n), .req(dreq), .done(div_done), .quotient(div_q)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg <= 4'd2;
            dm_reg <= 9'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CLUSTER_COUNT: cc_reg <= cfg_data[3:0];
                CFG_DIST_MIX:      dm_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // operand helpers
    assign cur_lvl  = lvl_tab[c_reg][k_reg];
    assign cur_d    = {cur_lvl[8], cur_lvl, 8'd0};
    assign cur_s    = {2'b00, s_reg[k_reg]};
    assign cur_diff = cur_s - cur_d;
    assign dot_abs  = dot_reg[34] ? 34'(-dot_reg) : dot_reg[33:0];
    assign mm       = 9'(9'd256 - m_reg);
    assign ld_addr  = IW'(ld_idx_reg);
    assign ld_in_range = ({29'd0, ld_idx_reg} < 32'(NCLUSTERS));

    always_comb
    begin
        if (cc_reg == 4'd0)
            n_sat = 1;
        else if (32'(cc_reg) > 32'(NCLUSTERS))
            n_sat = NCLUSTERS;
        else
            n_sat = 32'(cc_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    if (action)
                        state_next = ST_LOAD;
                    else if (in_mask)
                        state_next = ST_PROD;
                    else
                        state_next = ST_OUT;
                end
            ST_LOAD:
                if (op_reg == 2'd3)
                    state_next = ST_IDLE;
            ST_PROD:
                if (op_reg == 2'd2 && k_reg == KLAST)
                    state_next = (m_reg != 9'd0) ? ST_DOT : ST_MIX;
            ST_DOT:
                if (op_reg == 2'd2)
                    state_next = ST_DS1;
            ST_DS1:
                state_next = ST_DV1;
            ST_DV1:
                if (div_done)
                    state_next = ST_MIX;
            ST_MIX:
                if (op_reg == 2'd3)
                    state_next = ST_DS2;
            ST_DS2:
                state_next = ST_DV2;
            ST_DV2:
                if (div_done)
                    state_next = (c_reg == nlast_reg) ? ST_OUT : ST_PROD;
            ST_OUT:
                if (out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and multiplier operand select
    always_comb
    begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        dreq.start    = 1'b0;
        dreq.dividend = dsq_reg;
        dreq.divisor  = norm_tab[c_reg];
        mul_a         = '0;
        mul_b         = '0;
        unique case (state_reg)
            ST_IDLE:
                in_ready = 1'b1;
            ST_LOAD:
                if (op_reg == 2'd3)
                begin
                    mul_a = {2'b00, ld_w_reg};
                    mul_b = {2'b00, ld_w_reg};
                end
                else
                begin
                    mul_a = 18'(signed'(ld_lvl_reg[op_reg]));
                    mul_b = 18'(signed'(ld_lvl_reg[op_reg]));
                end
            ST_PROD:
                case (op_reg)
                    2'd0:
                    begin
                        mul_a = cur_diff;
                        mul_b = cur_diff;
                    end
                    2'd1:
                    begin
                        mul_a = cur_s;
                        mul_b = cur_d;
                    end
                    default:
                    begin
                        mul_a = cur_s;
                        mul_b = cur_s;
                    end
                endcase
            ST_DOT:
                case (op_reg)
                    2'd0:
                    begin
                        mul_a = {1'b0, dot_abs[16:0]};
                        mul_b = {1'b0, dot_abs[16:0]};
                    end
                    2'd1:
                    begin
                        mul_a = {1'b0, dot_abs[33:17]};
                        mul_b = {1'b0, dot_abs[16:0]};
                    end
                    default:
                    begin
                        mul_a = {1'b0, dot_abs[33:17]};
                        mul_b = {1'b0, dot_abs[33:17]};
                    end
                endcase
            ST_DS1:
                dreq.start = 1'b1;
            ST_MIX:
                case (op_reg)
                    2'd0:
                    begin
                        mul_a = {1'b0, line_reg[16:0]};
                        mul_b = {9'd0, m_reg};
                    end
                    2'd1:
                    begin
                        mul_a = {1'b0, line_reg[33:17]};
                        mul_b = {9'd0, m_reg};
                    end
                    2'd2:
                    begin
                        mul_a = {1'b0, r_reg[16:0]};
                        mul_b = {9'd0, mm};
                    end
                    default:
                    begin
                        mul_a = {1'b0, r_reg[33:17]};
                        mul_b = {9'd0, mm};
                    end
                endcase
            ST_DS2:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = {9'd0, mix_reg, 16'd0};
                dreq.divisor  = {2'b00, wsq_tab[c_reg]};
            end
            ST_OUT:
                out_valid = 1'b1;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // table writes; reset gives unused levels, unit weight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCLUSTERS; i++)
            begin
                for (int j = 0; j < 3; j++)
                    lvl_tab[i][j] <= 9'h1FF;
                norm_tab[i] <= 34'd1;
                wsq_tab[i]  <= 32'd65536;
                ph_tab[i]   <= 8'd255;
            end
        end
        else if (state_reg == ST_LOAD && op_reg == 2'd3 && ld_in_range)
        begin
            for (int j = 0; j < 3; j++)
                lvl_tab[ld_addr][j] <= ld_lvl_reg[j];
            norm_tab[ld_addr] <= (nacc_reg == 18'd0) ? 34'd1 : {nacc_reg, 16'd0};
            wsq_tab[ld_addr]  <= (prod[31:0] == 32'd0) ? 32'd1 : prod[31:0];
            ph_tab[ld_addr]   <= ld_ph_reg;
        end
    end

    // sequencer counters and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg    <= '0;
            k_reg     <= '0;
            c_reg     <= '0;
            nlast_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    op_reg    <= '0;
                    k_reg     <= '0;
                    c_reg     <= '0;
                    nlast_reg <= IW'(n_sat - 1);
                end
                ST_LOAD:
                    op_reg <= op_reg + 2'd1;
                ST_PROD:
                    if (op_reg == 2'd2)
                    begin
                        op_reg <= '0;
                        k_reg  <= k_reg + 2'd1;
                    end
                    else
                        op_reg <= op_reg + 2'd1;
                ST_DOT:
                    op_reg <= (op_reg == 2'd2) ? 2'd0 : op_reg + 2'd1;
                ST_MIX:
                    op_reg <= op_reg + 2'd1;
                ST_DV2:
                    if (div_done)
                    begin
                        c_reg  <= c_reg + IW'(1);
                        k_reg  <= '0;
                        op_reg <= '0;
                    end
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    s_reg[0]      <= sample_a;
                    s_reg[1]      <= sample_b;
                    s_reg[2]      <= sample_c;
                    m_reg         <= (dm_reg > 9'd256) ? 9'd256 : dm_reg;
                    ld_lvl_reg[0] <= level_a;
                    ld_lvl_reg[1] <= level_b;
                    ld_lvl_reg[2] <= level_c;
                    ld_idx_reg    <= entry_index;
                    ld_w_reg      <= entry_weight;
                    ld_ph_reg     <= entry_phase;
                    nacc_reg      <= '0;
                    r_reg         <= '0;
                    sq_reg        <= '0;
                    dot_reg       <= '0;
                    line_reg      <= '0;
                    ph_out_reg    <= 8'd0;
                    win_out_reg   <= 3'd0;
                    cls_out_reg   <= 1'b0;
                end
            ST_LOAD:
                if (32'(op_reg) < 32'(NCOMPONENTS))
                    nacc_reg <= nacc_reg + prod[17:0];
            ST_PROD:
                case (op_reg)
                    2'd0: r_reg <= r_reg + (cur_lvl[8] ? UNUSED_PENALTY : prod[33:0]);
                    2'd1: dot_reg <= dot_reg + $signed(prod[34:0]);
                    default: sq_reg <= sq_reg + prod[33:0];
                endcase
            ST_DOT:
                case (op_reg)
                    2'd0: dsq_reg <= {32'd0, prod};
                    2'd1: dsq_reg <= dsq_reg + {14'd0, prod, 18'd0};
                    default: dsq_reg <= dsq_reg + {prod[33:0], 34'd0};
                endcase
            ST_DV1:
                if (div_done)
                    line_reg <= (div_q > {30'd0, sq_reg}) ? 34'd0 : sq_reg - div_q[33:0];
            ST_MIX:
                case (op_reg)
                    2'd0: mix_reg <= {7'd0, prod};
                    2'd1: mix_reg <= mix_reg + {prod[25:0], 17'd0};
                    2'd2: mix_reg <= mix_reg + {7'd0, prod};
                    default: mix_reg <= mix_reg + {prod[25:0], 17'd0};
                endcase
            ST_DV2:
                if (div_done)
                begin
                    // first minimum wins: strict compare keeps the lower index
                    if (c_reg == '0 || div_q < best_q_reg)
                    begin
                        best_q_reg  <= div_q;
                        ph_out_reg  <= ph_tab[c_reg];
                        win_out_reg <= 3'(c_reg);
                    end
                    cls_out_reg <= 1'b1;
                    r_reg       <= '0;
                    sq_reg      <= '0;
                    dot_reg     <= '0;
                    line_reg    <= '0;
                end
            default:
                ;
        endcase
    end

    assign phase_out  = ph_out_reg;
    assign winner     = win_out_reg;
    assign classified = cls_out_reg;
endmodule

[src/wncp_check.sv]
// Port-level checks for the weighted nearest colour phase classifier.
// Depends on weighted_nearest_color_phase (bound below).
module wncp_check (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] phase_out,
    input logic [2:0] winner,
    input logic       classified
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result word waits");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready straight after an accepted word");

    a_masked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !classified) |-> (phase_out == 8'd0 && winner == 3'd0))
        else $error("masked pixel with non-zero result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(phase_out)
            && $stable(winner) && $stable(classified)))
        else $error("result word changed while stalled");
endmodule

bind weighted_nearest_color_phase wncp_check u_wncp_check (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .phase_out(phase_out),
    .winner(winner), .classified(classified)
);
